@@ hdl/address_list_cam_defines.svh @@
// Assertion macros for the address list CAM.
// Included by modules that check their own logic; needs clk and rst_n in scope.
`ifndef ADDRESS_LIST_CAM_DEFINES_SVH
`define ADDRESS_LIST_CAM_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define ALC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("address_list_cam: check failed");
// Next-cycle implication, checked outside reset.
`define ALC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("address_list_cam: check failed");
`else
`define ALC_ASSERT_IMP(label, ante, cons)
`define ALC_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ hdl/alc_pkg.sv @@
// Shared types and constants for the address list CAM.
// No dependencies; used by alc_cell and address_list_cam.
package alc_pkg;

    localparam int DEFAULT_LIST_DEPTH = 16;
    localparam int ENTRY_W            = 56;
    localparam int ADDR_W             = 48;
    localparam int ATYPE_W            = 8;
    localparam int CMD_W              = 2;
    localparam int COUNT_OUT_W        = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    typedef logic [ENTRY_W-1:0] entry_t;

    // Per-cell strobes from the sequencer
    typedef struct packed {
        logic cmp;    // register compare result
        logic load;   // store the key (append)
        logic shift;  // take the upper neighbour's entry (remove)
    } cell_ctrl_t;

endpackage

@@ hdl/alc_cell.sv @@
// One slot of the address list: holds an entry and its compare result.
// Depends on alc_pkg.
module alc_cell
    import alc_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     key,
    input  logic       in_range,   // slot index below the entry count
    input  entry_t     nbr_entry,  // entry of the slot above
    output entry_t     entry,
    output logic       match
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   match_reg;
    logic   match_next;

    // Next entry: append, shift down or hold; next match flag: compare or hold
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load)
        begin
            entry_next = key;
        end
        else if (ctrl.shift)
        begin
            entry_next = nbr_entry;
        end
        match_next = match_reg;
        if (ctrl.cmp)
        begin
            match_next = in_range && (entry_reg == key);
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

@@ hdl/address_list_cam.sv @@
// Address list CAM top level: command sequencer, count and a row of alc_cell slots.
// Depends on alc_pkg, alc_cell and address_list_cam_defines.svh.
//
//  channel | dir | tdata fields (lowest bit first)
//  s_*     | in  | cmd[1:0], addr[49:2], atype[57:50], zero pad to 64
//  m_*     | out | ok[0], entry_count[5:1], zero pad to 8
//
// Each command passes through accept, compare in every slot, prefix of the
// match flags, then update of the slots and the count with the result written.
// The update waits while the previous result is not yet taken on m_*.
// A new command is accepted while a result waits in the output register.
// Reset clears the count and control state; slot contents stay undefined
// and are never read above the count.
`include "address_list_cam_defines.svh"
module address_list_cam
    import alc_pkg::*;
#(
    parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // cmd[1:0], addr[49:2], atype[57:50]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // ok[0], entry_count[5:1]
);

    localparam int CW = $clog2(LIST_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_PFX  = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [CMD_W-1:0]      cmd_reg;
    entry_t                key_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [LIST_DEPTH-1:0] shift_vec_reg;
    logic [LIST_DEPTH-1:0] shift_vec_next;
    logic                  found_reg;
    logic                  m_valid_reg;
    logic [7:0]            m_data_reg;
    logic [7:0]            m_data_next;

    logic [LIST_DEPTH-1:0] match_vec;
    entry_t                entry_vec [LIST_DEPTH];
    cell_ctrl_t            ctrl_vec  [LIST_DEPTH];

    logic                  accept;
    logic                  upd_go;
    logic                  add_ok;
    logic                  rm_ok;
    logic                  res_ok;
    logic                  full;
    logic [CW+COUNT_OUT_W-1:0] count_wide;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign upd_go   = (state_reg == ST_UPD) && (!m_valid_reg || m_tready);
    assign full     = (count_reg == CW'(LIST_DEPTH));
    assign add_ok   = (cmd_reg == CMD_ADD) && !found_reg && !full;
    assign rm_ok    = (cmd_reg == CMD_REMOVE) && found_reg;

    // Row of slots; each hands its entry to the slot below on a remove
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        entry_t nbr;
        logic   in_range;

        if (i == LIST_DEPTH - 1)
        begin : g_top
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = entry_vec[i+1];
        end

        assign in_range       = (CW'(i) < count_reg);
        assign ctrl_vec[i].cmp   = (state_reg == ST_CMP);
        assign ctrl_vec[i].load  = upd_go && add_ok && (CW'(i) == count_reg);
        assign ctrl_vec[i].shift = upd_go && rm_ok && shift_vec_reg[i];

        alc_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl_vec[i]),
            .key       (key_reg),
            .in_range  (in_range),
            .nbr_entry (nbr),
            .entry     (entry_vec[i]),
            .match     (match_vec[i])
        );
    end

    // Prefix OR of match flags: every slot from the hit upwards shifts down
    always_comb
    begin
        shift_vec_next = match_vec;
        for (int s = 1; s < LIST_DEPTH; s = s * 2)
        begin
            shift_vec_next = shift_vec_next | (shift_vec_next << s);
        end
    end

    // Result and count update
    always_comb
    begin
        count_next = count_reg;
        if (add_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rm_ok)
        begin
            count_next = count_reg - CW'(1);
        end
        unique case (cmd_reg)
            CMD_ADD:    res_ok = add_ok;
            CMD_REMOVE: res_ok = rm_ok;
            CMD_QUERY:  res_ok = found_reg;
            default:    res_ok = 1'b0;
        endcase
        count_wide  = (CW+COUNT_OUT_W)'(count_next);
        m_data_next = {2'b00, count_wide[COUNT_OUT_W-1:0], res_ok};
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_CMP;
            ST_CMP:  state_next = ST_PFX;
            ST_PFX:  state_next = ST_UPD;
            ST_UPD:  if (upd_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (upd_go)
            begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= s_tdata[CMD_W-1:0];
            key_reg <= {s_tdata[CMD_W+ADDR_W+ATYPE_W-1:CMD_W+ADDR_W],
                        s_tdata[CMD_W+ADDR_W-1:CMD_W]};
        end
        if (state_reg == ST_PFX)
        begin
            shift_vec_reg <= shift_vec_next;
            found_reg     <= |match_vec;
        end
        if (upd_go)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Checks
    `ALC_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(LIST_DEPTH))
    `ALC_ASSERT_IMP(a_unique_hit, state_reg == ST_PFX, $onehot0(match_vec))
    `ALC_ASSERT_IMP(a_shift_found, state_reg == ST_UPD, (shift_vec_reg != '0) == found_reg)
    `ALC_ASSERT_NXT(a_remove_count, upd_go && rm_ok, count_reg == $past(count_reg) - CW'(1))
    `ALC_ASSERT_NXT(a_accept_cmp, accept, state_reg == ST_CMP)

endmodule
